@@ design/plfh_pkg.sv @@
`default_nettype none

package plfh_pkg;

  localparam int unsigned IDX_W     = 8;
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned RGB_W     = 24;
  localparam int unsigned HASH_W    = 64;

  // item kinds carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]        DAC_MAX      = 8'd63;
  localparam logic [HASH_W-1:0] HASH_BASIS   = 64'd1469598103934665603;

  typedef struct packed {
    logic             step;
    logic             last;
    logic [IDX_W-1:0] idx;
  } hash_cmd_t;

  // 6-bit DAC value to 8 bits; larger bytes pass as given
  function automatic logic [7:0] widen(input logic [7:0] v);
    logic [7:0] w;
    if (v <= DAC_MAX) begin
      w = {v[5:0], v[5:4]};
    end else begin
      w = v;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/plfh_ram.sv @@
`default_nettype none

module plfh_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/plfh_hash.sv @@
`default_nettype none

module plfh_hash (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire plfh_pkg::hash_cmd_t           cmd,
  output logic      [plfh_pkg::HASH_W-1:0]   frame_hash,
  output logic                               hash_valid
);

  logic [plfh_pkg::HASH_W-1:0] run_r, run_nxt;
  logic [plfh_pkg::HASH_W-1:0] frame_r, frame_nxt;
  logic                        done_r, done_nxt;
  logic [plfh_pkg::HASH_W-1:0] mixed;
  logic [plfh_pkg::HASH_W-1:0] prod;

  // multiply by the FNV prime 2^40 + 0x1B3 as a shift-add
  always_comb begin
    mixed = run_r ^ {{(plfh_pkg::HASH_W-plfh_pkg::IDX_W){1'b0}}, cmd.idx};
    prod  = mixed + (mixed << 1) + (mixed << 4) + (mixed << 5)
          + (mixed << 7) + (mixed << 8) + (mixed << 40);
  end

  always_comb begin
    run_nxt   = run_r;
    frame_nxt = frame_r;
    done_nxt  = done_r;
    if (cmd.step) begin
      done_nxt = cmd.last;
      if (cmd.last) begin
        run_nxt   = plfh_pkg::HASH_BASIS;
        frame_nxt = prod;
      end else begin
        run_nxt   = prod;
        frame_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= plfh_pkg::HASH_BASIS;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frame_hash = frame_r;
  assign hash_valid = done_r;

endmodule

`default_nettype wire

@@ design/palette_lookup_with_frame_hash.sv @@
`default_nettype none

// channel | dir | tdata (low bit up)                      | tuser | tlast
// in_     | in  | index[7:0] red[15:8] green[23:16] blue[31:24] | func  | last_pixel
// out_    | out | argb[31:0] frame_hash[95:32]             | -     | hash_valid
//
// One item per cycle sustained while out_tready is high; a pixel's result
// passes through the palette RAM read and then the output register.
// The hash recurrence closes through a combinational shift-add by the prime.
// Reset clears per-entry valid bits so unwritten entries read as black; there
// is no clearing pass. When the output stalls, one pixel waits in the read
// stage and further items stall.

module palette_lookup_with_frame_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // index, red, green, blue
  input  wire logic        in_tuser,   // func
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [95:0] out_tdata,  // argb, frame_hash
  output logic             out_tlast   // hash_valid
);

  logic [plfh_pkg::IDX_W-1:0]     in_idx;
  logic [plfh_pkg::RGB_W-1:0]     wr_rgb;
  logic                           accept;
  logic                           pix_acc;
  logic                           wr_acc;
  logic [plfh_pkg::RGB_W-1:0]     rd_data;

  logic [plfh_pkg::PAL_DEPTH-1:0] pv_r, pv_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_hit_r;
  logic                           s1_move;

  logic                           out_valid_r, out_valid_nxt;
  logic [95:0]                    out_data_r;
  logic                           out_last_r;

  logic [plfh_pkg::HASH_W-1:0]    frame_hash;
  logic                           hash_valid;
  plfh_pkg::hash_cmd_t            hcmd;

  assign in_idx  = in_tdata[7:0];
  assign wr_rgb  = {plfh_pkg::widen(in_tdata[15:8]),
                    plfh_pkg::widen(in_tdata[23:16]),
                    plfh_pkg::widen(in_tdata[31:24])};

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;
  assign pix_acc   = accept && (in_tuser == plfh_pkg::FUNC_PIXEL);
  assign wr_acc    = accept && (in_tuser == plfh_pkg::FUNC_WRITE);

  plfh_ram #(
    .WIDTH(plfh_pkg::RGB_W),
    .DEPTH(plfh_pkg::PAL_DEPTH)
  ) u_pal (
    .clk    (clk),
    .wr_en  (wr_acc),
    .wr_addr(in_idx),
    .wr_data(wr_rgb),
    .rd_en  (pix_acc),
    .rd_addr(in_idx),
    .rd_data(rd_data)
  );

  assign hcmd.step = pix_acc;
  assign hcmd.last = in_tlast;
  assign hcmd.idx  = in_idx;

  plfh_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (hcmd),
    .frame_hash(frame_hash),
    .hash_valid(hash_valid)
  );

  always_comb begin
    pv_nxt = pv_r;
    if (wr_acc) begin
      pv_nxt[in_idx] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pix_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r        <= pv_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_hit_r <= pv_r[in_idx];
    end
    if (s1_move) begin
      out_data_r <= {frame_hash, plfh_pkg::ALPHA_OPAQUE,
                     (s1_hit_r ? rd_data : {plfh_pkg::RGB_W{1'b0}})};
      out_last_r <= hash_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // stall only when both the read stage and the output register are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  a_pix_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc |=> s1_valid_r)
    else $error("accepted pixel lost before the read stage");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:24] == plfh_pkg::ALPHA_OPAQUE))
    else $error("result alpha not opaque");

  a_hash_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[95:32] == 64'd0))
    else $error("frame hash nonzero on a non-last pixel");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

typedef struct {
  logic [31:0] argb;
  logic [63:0] frame_hash;
  logic        hash_valid;
} pixel_result_t;

class PaletteScoreboard;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

  logic [23:0]   palette [256];
  logic [63:0]   hash_acc;
  pixel_result_t pixel_q[$];
  int            fail_count;
  int            write_count;
  int            pixel_count;
  int            frames_hashed;

  function new();
    foreach (palette[i]) palette[i] = '0;
    hash_acc      = plfh_pkg::HASH_BASIS;
    fail_count    = 0;
    write_count   = 0;
    pixel_count   = 0;
    frames_hashed = 0;
  endfunction

  function logic [7:0] dac_to_byte(logic [7:0] v);
    if (v <= 8'd63) return {v[5:0], v[5:4]};
    return v;
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    fail_count++;
  endtask

  // Update the palette or the frame hash for one accepted input transaction.
  function void note_input(logic func, logic [7:0] idx, logic [7:0] red, logic [7:0] green,
                           logic [7:0] blue, logic last);
    pixel_result_t res;
    if (func == plfh_pkg::FUNC_WRITE) begin
      palette[idx] = {dac_to_byte(red), dac_to_byte(green), dac_to_byte(blue)};
      write_count++;
      return;
    end
    hash_acc = (hash_acc ^ {56'd0, idx}) * FNV_PRIME;
    res.argb = {8'hFF, palette[idx]};
    if (last) begin
      res.frame_hash = hash_acc;
      res.hash_valid = 1'b1;
      hash_acc = plfh_pkg::HASH_BASIS;
    end else begin
      res.frame_hash = '0;
      res.hash_valid = 1'b0;
    end
    pixel_q.push_back(res);
  endfunction

  task check_result(logic [31:0] argb, logic [63:0] frame_hash, logic hash_valid);
    pixel_result_t want;
    if (pixel_q.size() == 0) begin
      report("unexpected result", {frame_hash[31:0], argb}, '0);
      return;
    end
    want = pixel_q.pop_front();
    pixel_count++;
    if (want.hash_valid) frames_hashed++;
    if (argb !== want.argb) report("argb", argb, want.argb);
    if (frame_hash !== want.frame_hash) report("frame_hash", frame_hash, want.frame_hash);
    if (hash_valid !== want.hash_valid) report("hash_valid", hash_valid, want.hash_valid);
  endtask

  function int pending();
    return pixel_q.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 500;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;

  PaletteScoreboard sb;
  int cycles    = 0;
  int sent      = 0;
  int burst_len = 0;
  int gap_len   = 0;
  int rx_mode   = 0;
  int hold_left = 0;

  palette_lookup_with_frame_hash uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Check results before noting inputs; a pixel never returns on its own edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata[31:0], out_tdata[95:32], out_tlast);
      end
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                      in_tdata[31:24], in_tlast);
      end
    end
  end

  // Receiver: switch between always ready, coin-flip and occasional long holds.
  always @(negedge clk) begin
    if (cycles % 128 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          hold_left = $urandom_range(5, 25);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Called at a falling edge; returns at a falling edge.
  task send_item(logic func, logic [7:0] idx, logic [7:0] red, logic [7:0] green,
                 logic [7:0] blue, logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= {blue, green, red, idx};
    in_tuser  <= func;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
    if (burst_len == 0) begin
      burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap_len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_len--;
    if (burst_len == 0 && gap_len > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
  endtask

  function logic [7:0] pick_component();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(0, 255));
  endfunction

  // Favor a few entries so lookups often hit written colors.
  function logic [7:0] pick_index();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task send_write();
    send_item(plfh_pkg::FUNC_WRITE, pick_index(), pick_component(), pick_component(),
              pick_component(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int frame_len;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset-black lookup, DAC boundary values (0, 63, 64, 255), ignored last on a write,
    // single-pixel frames and an overwrite.
    send_item(plfh_pkg::FUNC_PIXEL, 8'd7,   8'd0,   8'd0,   8'd0,   1'b0);
    send_item(plfh_pkg::FUNC_WRITE, 8'd0,   8'd0,   8'd63,  8'd64,  1'b1);
    send_item(plfh_pkg::FUNC_WRITE, 8'd255, 8'd255, 8'd1,   8'd32,  1'b0);
    send_item(plfh_pkg::FUNC_WRITE, 8'd128, 8'd63,  8'd62,  8'd16,  1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd128, 8'd0,   8'd0,   8'd0,   1'b1);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_item(plfh_pkg::FUNC_WRITE, 8'd0,   8'd65,  8'd0,   8'd255, 1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd7,   8'd0,   8'd0,   8'd0,   1'b0);
    send_item(plfh_pkg::FUNC_WRITE, 8'd7,   8'd15,  8'd48,  8'd33,  1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd7,   8'd0,   8'd0,   8'd0,   1'b1);
    send_item(plfh_pkg::FUNC_WRITE, 8'd255, 8'd64,  8'd254, 8'd63,  1'b1);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
    send_item(plfh_pkg::FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1);

    // Random frames of pixels with palette writes mixed in.
    while (sent < RANDOM_ITEMS + 16) begin
      frame_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
      for (int p = 0; p < frame_len; p++) begin
        if ($urandom_range(0, 4) == 0) send_write();
        send_item(plfh_pkg::FUNC_PIXEL, pick_index(), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'(p == frame_len - 1));
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions: %0d palette writes, %0d pixel results, %0d frame hashes",
             sent, sb.write_count, sb.pixel_count, sb.frames_hashed);
    if (sb.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
